### rtl/core/deq_pkg.sv
// Package with the sizes, codes and ring index helpers of the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none
package deq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int DATA_W = 32;
    localparam int FILL_W = 5;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    // Fields that travel alongside a pending ring read.
    typedef struct packed {
        logic              is_read;
        t_status           status;
        logic              is_empty;
        logic              is_full;
        logic [FILL_W-1:0] fill_count;
    } t_s1;

    // Position of the entry at a given offset from the head, wrapped around the ring.
    function automatic logic [ADDR_W-1:0] ring_pos(input logic [ADDR_W-1:0] head,
                                                   input logic [CNT_W-1:0]  offset);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(offset);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    // Position just in front of the head.
    function automatic logic [ADDR_W-1:0] ring_prev(input logic [ADDR_W-1:0] head);
        logic [ADDR_W-1:0] pos;
        if (head == '0) begin
            pos = ADDR_W'(DEPTH - 1);
        end else begin
            pos = head - ADDR_W'(1);
        end
        return pos;
    endfunction

    // Item count reduced to the width of the fill count field.
    function automatic logic [FILL_W-1:0] fill_of(input logic [CNT_W-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return wide[FILL_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/core/double_ended_queue_unit.sv
// Top level of the bounded double-ended queue of signed 32-bit items.
//
// The block takes one command item on the input channel (i_valid / o_ready) with an
// opcode and a push value, and returns exactly one result item on the output channel
// (o_valid / i_ready) with the item read, a status and the empty, full and fill count
// values after the command. Results come out in command order.
//
// Items live in a ring memory of DEPTH entries with a registered read. The
// head index and item count sit in registers and are updated in the cycle a command is
// accepted, so the next command already sees the new state; a push writes the ring in
// that same cycle and a pop or peek launches its read then.
//
// An accepted command passes through the ring read and then the output register
// before o_valid rises. While the receiver keeps i_ready high, throughput is one
// command per cycle, set by the single read and single write port of the ring.
// When the receiver holds i_ready low the result waits in the output register, one
// more command may complete its ring read behind it, and then o_ready drops until
// the output register drains.
//
// Reset (i_rst_n low, synchronous) empties the queue and drops any pending result. The
// ring contents are not cleared; only entries that were pushed are ever read.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_queue_unit
    import deq_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [2:0]               i_opcode,
    input  wire logic signed [DATA_W-1:0] i_push_value,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic signed [DATA_W-1:0]      o_read_value,
    output logic [1:0]                    o_status,
    output logic                          o_is_empty,
    output logic                          o_is_full,
    output logic [FILL_W-1:0]             o_fill_count
);

    // Queue state.
    logic [ADDR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;

    // Stage one: a command whose ring read is in flight or done.
    logic r_s1_valid;
    t_s1  r_s1, n_s1;

    // Output register.
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    t_s1               r_out;

    // Ring port signals.
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;

    logic    in_go;
    logic    s1_go;
    logic    is_empty_now;
    logic    is_full_now;
    t_op     op;
    t_status status;

    // Stage one moves on when the output register is free or being emptied.
    assign s1_go   = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_go;
    assign in_go   = i_valid && o_ready;

    assign is_empty_now = (r_count == '0);
    assign is_full_now  = (r_count == CNT_W'(DEPTH));
    assign op           = t_op'(i_opcode);

    // Decode of the command against the current head and count.
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        wr_en   = 1'b0;
        wr_addr = ring_prev(r_head);
        rd_en   = 1'b0;
        rd_addr = r_head;
        status  = ST_OK;
        case (op)
            OP_PUSH_FRONT: begin
                if (is_full_now) begin
                    status = ST_OVERFLOW;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = ring_prev(r_head);
                    n_head  = ring_prev(r_head);
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_PUSH_BACK: begin
                if (is_full_now) begin
                    status = ST_OVERFLOW;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = ring_pos(r_head, r_count);
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
                if (is_empty_now) begin
                    status = ST_UNDERFLOW;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_head;
                    if (op == OP_POP_FRONT) begin
                        n_head  = ring_pos(r_head, CNT_W'(1));
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
                if (is_empty_now) begin
                    status = ST_UNDERFLOW;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = ring_pos(r_head, r_count - CNT_W'(1));
                    if (op == OP_POP_BACK) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            default: begin
                // Unused opcodes leave the queue alone and report it as it stands.
            end
        endcase

        n_s1.is_read    = rd_en;
        n_s1.status     = status;
        n_s1.is_empty   = (n_count == '0);
        n_s1.is_full    = (n_count == CNT_W'(DEPTH));
        n_s1.fill_count = fill_of(n_count);
    end

    deq_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (in_go && wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_push_value),
        .i_rd_en   (in_go && rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_go) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
            if (in_go) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_s1 <= n_s1;
        end
        if (s1_go) begin
            r_out       <= r_s1;
            r_out_value <= r_s1.is_read ? rd_data : '0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_status     = r_out.status;
    assign o_is_empty   = r_out.is_empty;
    assign o_is_full    = r_out.is_full;
    assign o_fill_count = r_out.fill_count;

endmodule
`default_nettype wire

### rtl/core/deq_ram.sv
// Ring storage of the double-ended queue: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module deq_ram
    import deq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read, so a stalled result keeps its item.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

### rtl/core/deq_checker.sv
// Port-level checks for the double-ended queue, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module deq_port_checks
    import deq_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     o_valid,
    input wire logic                     i_ready,
    input wire logic signed [DATA_W-1:0] o_read_value,
    input wire logic [1:0]               o_status,
    input wire logic                     o_is_empty,
    input wire logic                     o_is_full,
    input wire logic [FILL_W-1:0]        o_fill_count
);

    // An empty queue reports a zero fill count and is never full at once.
    a_empty_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> (o_fill_count == '0) && !o_is_full)
        else $error("empty result with nonzero count or full flag");

    // An underflow leaves an empty queue and reads nothing.
    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_UNDERFLOW) |-> o_is_empty && (o_read_value == '0))
        else $error("underflow on a non-empty queue");

    // An overflow leaves a full queue and reads nothing.
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_OVERFLOW) |-> o_is_full && (o_read_value == '0))
        else $error("overflow on a queue that is not full");

    // A stalled result holds its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_value) && $stable(o_status)
            && $stable(o_fill_count))
        else $error("result changed while stalled");

    // No result is presented right after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind double_ended_queue_unit deq_port_checks u_deq_port_checks (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_read_value (o_read_value),
    .o_status     (o_status),
    .o_is_empty   (o_is_empty),
    .o_is_full    (o_is_full),
    .o_fill_count (o_fill_count)
);
`default_nettype wire

### verif/deq_checker.sv
// Checker that predicts every result of the double-ended queue and compares it with the block.
`timescale 1ns / 1ps
module deq_checker
    import deq_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    input  wire logic                     i_in_ready,
    input  wire logic [2:0]               i_opcode,
    input  wire logic signed [DATA_W-1:0] i_push_value,
    input  wire logic                     i_out_valid,
    input  wire logic                     i_out_ready,
    input  wire logic signed [DATA_W-1:0] i_read_value,
    input  wire logic [1:0]               i_status,
    input  wire logic                     i_is_empty,
    input  wire logic                     i_is_full,
    input  wire logic [FILL_W-1:0]        i_fill_count,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [1:0]               status;
        logic                     empty;
        logic                     full;
        logic [FILL_W-1:0]        fill;
    } deq_reply_t;

    logic signed [DATA_W-1:0] slots [DEPTH];
    int                       front_pos;
    int                       held;
    deq_reply_t               awaited_replies [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        front_pos    = 0;
        held         = 0;
    end

    // Applies one command to the shadow deque and returns the result it must produce.
    function automatic deq_reply_t apply_command(input logic [2:0] op,
                                                 input logic signed [DATA_W-1:0] val);
        deq_reply_t r;
        r.value  = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH_FRONT: begin
                if (held >= DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    front_pos        = (front_pos + DEPTH - 1) % DEPTH;
                    slots[front_pos] = val;
                    held++;
                end
            end
            OP_PUSH_BACK: begin
                if (held >= DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    slots[(front_pos + held) % DEPTH] = val;
                    held++;
                end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
                if (held == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    r.value = slots[front_pos];
                    if (op == OP_POP_FRONT) begin
                        front_pos = (front_pos + 1) % DEPTH;
                        held--;
                    end
                end
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
                if (held == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    r.value = slots[(front_pos + held - 1) % DEPTH];
                    if (op == OP_POP_BACK) begin
                        held--;
                    end
                end
            end
            default: begin
                // Spare opcodes leave the deque alone and just report its state.
            end
        endcase
        r.empty = (held == 0);
        r.full  = (held == DEPTH);
        r.fill  = FILL_W'(held);
        return r;
    endfunction

    task automatic log_failure(input string what, input deq_reply_t want,
                               input deq_reply_t got);
        if (o_fail_count < 10) begin
            $display("%0t: %s: expected value %0d status %0d empty %0b full %0b fill %0d,",
                     $realtime, what, want.value, want.status, want.empty, want.full,
                     want.fill);
            $display("    got value %0d status %0d empty %0b full %0b fill %0d",
                     got.value, got.status, got.empty, got.full, got.fill);
        end
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        deq_reply_t want;
        deq_reply_t got;
        if (!i_rst_n) begin
            front_pos = 0;
            held      = 0;
            awaited_replies.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                awaited_replies.push_back(apply_command(i_opcode, i_push_value));
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_read_value, i_status, i_is_empty, i_is_full, i_fill_count};
                if (awaited_replies.size() == 0) begin
                    log_failure("result with no command waiting", '0, got);
                end else begin
                    want = awaited_replies.pop_front();
                    if (want !== got) begin
                        log_failure("result mismatch", want, got);
                    end
                end
            end
        end
        o_pending = awaited_replies.size();
    end

endmodule

### verif/tb.sv
// Testbench top for the double-ended queue: clock, reset, command stimulus and the verdict.
`timescale 1ns / 1ps
module tb;
    import deq_pkg::*;

    // The two opcodes that the block must treat as no operation.
    localparam logic [2:0] OP_SPARE_SIX   = 3'd6;
    localparam logic [2:0] OP_SPARE_SEVEN = 3'd7;

    // Bias of a burst of random commands: toward filling, toward draining, or even.
    localparam int BURST_FILL  = 0;
    localparam int BURST_DRAIN = 1;
    localparam int BURST_MIXED = 2;

    localparam int RANDOM_ITEMS   = 1550;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_valid      = 1'b0;
    logic [2:0]               i_opcode     = '0;
    logic signed [DATA_W-1:0] i_push_value = '0;
    logic                     i_ready      = 1'b0;
    logic                     o_ready;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_read_value;
    logic [1:0]               o_status;
    logic                     o_is_empty;
    logic                     o_is_full;
    logic [FILL_W-1:0]        o_fill_count;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int ready_hold  = 0;
    bit calm        = 1'b0;

    double_ended_queue_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full),
        .o_fill_count (o_fill_count)
    );

    // The checker sits beside the block, predicts each result and counts failures.
    deq_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_opcode     (i_opcode),
        .i_push_value (i_push_value),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_read_value (o_read_value),
        .i_status     (o_status),
        .i_is_empty   (o_is_empty),
        .i_is_full    (o_is_full),
        .i_fill_count (o_fill_count),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Idle gap before a command. Most are zero or short, a few are long, and none at all
    // while a calm burst runs, so that back-to-back traffic is covered too.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(15, 40);
    endfunction

    // Push values lean on the extremes now and then; the rest toggle every bit at random.
    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 12) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom();
    endfunction

    // Opcode for a random command. A fill burst pushes three times in four, a drain burst
    // one time in five, so the deque swings between empty and full and the head wraps
    // both ways. A few spare opcodes are mixed in everywhere.
    function automatic logic [2:0] pick_op(input int bias);
        int r;
        int push_share;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            return $urandom_range(0, 1) ? OP_SPARE_SIX : OP_SPARE_SEVEN;
        end
        case (bias)
            BURST_FILL:  push_share = 75;
            BURST_DRAIN: push_share = 20;
            default:     push_share = 50;
        endcase
        if (r < 3 + push_share) begin
            return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end
        case ($urandom_range(0, 3))
            0:       return OP_POP_FRONT;
            1:       return OP_POP_BACK;
            2:       return OP_PEEK_FRONT;
            default: return OP_PEEK_BACK;
        endcase
    endfunction

    // Offers one command and returns at the clock edge that accepts it. The ready is
    // sampled at the falling edge, where it is settled, so the acceptance test never
    // races the block's own updates at the rising edge.
    task automatic send_cmd(input logic [2:0] op, input logic [DATA_W-1:0] val);
        int  gap;
        bit  taken;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_opcode     <= op;
        i_push_value <= val;
        do begin
            @(negedge i_clk);
            taken = o_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Result side: the receiver stalls now and then, mostly briefly, once in a while for
    // a long stretch, and never starts a stall during a calm burst.
    always @(posedge i_clk) begin
        int r;
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 20) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    ready_hold <= $urandom_range(1, 3);
                end else if (r < 95) begin
                    ready_hold <= $urandom_range(4, 8);
                end else begin
                    ready_hold <= $urandom_range(15, 40);
                end
            end
        end
    end

    // Cycles in which neither channel moved an item; a hang shows up here.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int sent;
        int bias;
        int burst_len;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: every pop and peek on an empty deque, the spare opcodes, the
        // extreme values through both ends, and a drain back to empty.
        send_cmd(OP_POP_FRONT, 32'h0);
        send_cmd(OP_POP_BACK, 32'h0);
        send_cmd(OP_PEEK_FRONT, 32'h0);
        send_cmd(OP_PEEK_BACK, 32'h0);
        send_cmd(OP_SPARE_SIX, 32'h1234_5678);
        send_cmd(OP_SPARE_SEVEN, 32'hffff_ffff);
        send_cmd(OP_PUSH_FRONT, 32'h7fff_ffff);
        send_cmd(OP_PUSH_BACK, 32'h8000_0000);
        send_cmd(OP_PUSH_FRONT, 32'hffff_ffff);
        send_cmd(OP_PUSH_BACK, 32'h0000_0000);
        send_cmd(OP_PEEK_FRONT, 32'h5555_5555);
        send_cmd(OP_PEEK_BACK, 32'haaaa_aaaa);
        send_cmd(OP_POP_BACK, 32'h0);
        send_cmd(OP_POP_FRONT, 32'h0);
        send_cmd(OP_POP_FRONT, 32'h0);
        send_cmd(OP_POP_BACK, 32'h0);
        send_cmd(OP_PEEK_BACK, 32'h0);
        send_cmd(OP_SPARE_SIX, 32'h0);

        // Random part in bursts, each with its own bias and sometimes with no idling, so
        // the deque runs into full and empty over and over with the head at every slot.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            bias      = $urandom_range(BURST_FILL, BURST_MIXED);
            burst_len = $urandom_range(10, 50);
            calm      = ($urandom_range(0, 4) == 0);
            repeat (burst_len) begin
                send_cmd(pick_op(bias), pick_value());
                sent++;
            end
        end
        calm    = 1'b0;
        i_valid <= 1'b0;

        // Let every outstanding result drain, then keep the clock running so that any result
        // the block should not produce would show.
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        repeat (20) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
